### rtl/core/rtc_pkg.sv
// Shared types, operation codes and constants for the three-wire RTC serial master.
package rtc_pkg;

    localparam int unsigned DEFAULT_BURST_BYTES = 8;
    localparam int unsigned DATA_W = 64;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SWRITE = 3'd1;
    localparam logic [2:0] OP_SREAD  = 3'd2;
    localparam logic [2:0] OP_BWRITE = 3'd3;
    localparam logic [2:0] OP_BREAD  = 3'd4;

    localparam logic [7:0] CMD_BWRITE = 8'hBE;
    localparam logic [7:0] CMD_BREAD  = 8'hBF;

    typedef struct packed {
        logic [2:0]        operation;
        logic [5:0]        reg_index;
        logic [DATA_W-1:0] write_data;
        logic              sio_in;
    } req_t;

    typedef struct packed {
        logic              chip_enable;
        logic              serial_clock;
        logic              sio_out;
        logic              sio_drive;
        logic              busy_res;
        logic [DATA_W-1:0] read_data;
        logic              read_valid;
    } res_t;

    // One classified tick as it waits between the front and the back.
    typedef struct packed {
        logic              start;
        logic [2:0]        operation;
        logic [7:0]        command;
        logic [DATA_W-1:0] data;
        logic              sio_in;
    } entry_t;

endpackage

### rtl/core/rtc_front.sv
// Front part: decodes each tick, builds the command byte and masks the write data.
module rtc_front
    import rtc_pkg::*;
#(
    parameter int unsigned BURST_BYTES = DEFAULT_BURST_BYTES
)
(
    input  req_t   req,
    output entry_t entry
);

    localparam logic [DATA_W-1:0] BURST_MASK = (BURST_BYTES >= 8) ? {DATA_W{1'b1}} :
        ((DATA_W'(1) << (8 * BURST_BYTES)) - DATA_W'(1));
    localparam logic [DATA_W-1:0] SINGLE_MASK = DATA_W'(8'hFF);

    always_comb
    begin
        entry.operation = req.operation;
        entry.sio_in    = req.sio_in;
        entry.start     = 1'b0;
        entry.command   = {1'b1, req.reg_index, 1'b0};
        entry.data      = req.write_data & SINGLE_MASK;
        case (req.operation)
            OP_SWRITE:
            begin
                entry.start = 1'b1;
            end
            OP_SREAD:
            begin
                entry.start   = 1'b1;
                entry.command = {1'b1, req.reg_index, 1'b1};
            end
            OP_BWRITE:
            begin
                entry.start   = 1'b1;
                entry.command = CMD_BWRITE;
                entry.data    = req.write_data & BURST_MASK;
            end
            OP_BREAD:
            begin
                entry.start   = 1'b1;
                entry.command = CMD_BREAD;
                entry.data    = req.write_data & BURST_MASK;
            end
            default:
            begin
                entry.start = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/rtc_queue.sv
// Short queue of classified ticks between the front and the back.
module rtc_queue
    import rtc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/core/rtc_back.sv
// Back part: the pin waveform sequencer and the result register.
module rtc_back
    import rtc_pkg::*;
#(
    parameter int unsigned BURST_BYTES = DEFAULT_BURST_BYTES
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   avail,
    input  entry_t entry,
    output logic   take,
    output logic   res_valid,
    input  logic   res_stall,
    output res_t   res
);

    localparam logic [6:0] SINGLE_TOTAL = 7'd16;
    localparam logic [6:0] BURST_TOTAL  = 7'(8 + 8 * BURST_BYTES);

    logic [2:0]        op_reg;
    logic [2:0]        op_next;
    logic [6:0]        bit_pos_reg;
    logic [6:0]        bit_pos_next;
    logic              phase_reg;
    logic              phase_next;
    logic [7:0]        cmd_reg;
    logic [7:0]        cmd_next;
    logic [DATA_W-1:0] tx_reg;
    logic [DATA_W-1:0] tx_next;
    logic [DATA_W-1:0] rx_reg;
    logic [DATA_W-1:0] rx_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    res_t              res_reg;
    res_t              res_next;
    logic [6:0]        total;
    logic [6:0]        data_off;
    logic              active;

    // A tick moves on whenever the result register is free or is emptied this cycle.
    assign take      = avail && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign total     = (op_reg inside {OP_BWRITE, OP_BREAD}) ? BURST_TOTAL : SINGLE_TOTAL;

    always_comb
    begin
        op_next      = op_reg;
        bit_pos_next = bit_pos_reg;
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        active       = 1'b0;
        res_next     = '0;
        data_off     = '0;

        if (op_reg == OP_TICK)
        begin
            if (entry.start)
            begin
                op_next      = entry.operation;
                bit_pos_next = '0;
                phase_next   = 1'b0;
                cmd_next     = entry.command;
                tx_next      = entry.data;
                rx_next      = '0;
                active       = 1'b1;
            end
        end
        else
        begin
            phase_next = !phase_reg;
            if (phase_reg)
            begin
                bit_pos_next = bit_pos_reg + 7'd1;
            end
            data_off = bit_pos_next - 7'd8;
            if (bit_pos_next >= total)
            begin
                if (op_reg inside {OP_SREAD, OP_BREAD})
                begin
                    res_next.read_valid = 1'b1;
                    res_next.read_data  = rx_reg;
                end
                op_next      = OP_TICK;
                bit_pos_next = '0;
                phase_next   = 1'b0;
            end
            else
            begin
                active = 1'b1;
                // Read bits are sampled in the low half, before SCK rises.
                if (!phase_next && (op_reg inside {OP_SREAD, OP_BREAD}) &&
                    (bit_pos_next >= 7'd8))
                begin
                    rx_next[data_off[5:0]] = entry.sio_in;
                end
            end
        end

        if (active)
        begin
            res_next.chip_enable  = 1'b1;
            res_next.busy_res     = 1'b1;
            res_next.serial_clock = phase_next;
            if (bit_pos_next < 7'd8)
            begin
                res_next.sio_drive = 1'b1;
                res_next.sio_out   = cmd_next[bit_pos_next[2:0]];
            end
            else if (!(op_next inside {OP_SREAD, OP_BREAD}))
            begin
                res_next.sio_drive = 1'b1;
                res_next.sio_out   = tx_next[data_off[5:0]];
            end
        end

        res_valid_next = res_valid_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_TICK;
            bit_pos_reg   <= '0;
            phase_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                op_reg      <= op_next;
                bit_pos_reg <= bit_pos_next;
                phase_reg   <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
            tx_reg  <= tx_next;
            rx_reg  <= rx_next;
            res_reg <= res_next;
        end
    end

endmodule

### rtl/core/three_wire_rtc_serial_master_core.sv
// Top level of the three-wire RTC serial master: front, queue and back joined.
//
// Every req beat is one tick of the CE/SCK/SIO waveform and may carry a request
// (single or burst, write or read); a request is only taken up while no transfer
// runs and is otherwise ignored. Every req beat yields exactly one res beat with
// the pin levels for that tick, busy_res, and on the finishing tick of a read
// the received data with read_valid set.
// A request tick already shows CE high and command bit 0 on SIO. Each later tick
// advances half a bit; single transfers span 32 ticks plus the finishing tick,
// bursts 16 + 16 * BURST_BYTES ticks plus the finishing tick.
// One beat is accepted per cycle while req_stall is low. A beat is classified and
// written to a four-entry queue as it is accepted, and the sequencer turns it
// into the result register once that register is free or is emptied.
// When the receiver stalls, the result register holds its beat, the queue fills,
// and req_stall rises once the queue is full.
// Reset empties the queue and the result register and puts the link idle.
module three_wire_rtc_serial_master_core
    import rtc_pkg::*;
#(
    parameter int unsigned BURST_BYTES = DEFAULT_BURST_BYTES
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    entry_t classified;
    entry_t head;
    logic   queue_full;
    logic   queue_avail;
    logic   take;

    assign req_stall = queue_full;

    rtc_front #(
        .BURST_BYTES (BURST_BYTES)
    ) u_front (
        .req   (req),
        .entry (classified)
    );

    rtc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (req_valid),
        .push_entry (classified),
        .full       (queue_full),
        .pop        (take),
        .not_empty  (queue_avail),
        .head       (head)
    );

    rtc_back #(
        .BURST_BYTES (BURST_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (queue_avail),
        .entry     (head),
        .take      (take),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
